// ===== hw/rtl/mmp_pkg.sv =====
// ----------------------------------------------------------------------------
// mmp_pkg
// Types and constants shared by the modular matrix power block.
// ----------------------------------------------------------------------------
package mmp_pkg;

    localparam int ENTRY_W     = 30;
    localparam int EXP_W       = 63;
    localparam int DEF_DIM     = 2;
    localparam int DEF_EXP_BITS = 63;
    localparam logic [29:0] PRIME = 30'd1000000007;
    localparam logic [31:0] PRIME_X2 = 32'd2000000014;
    // Barrett factor: floor(2^60 / PRIME).
    localparam logic [30:0] MU = 31'd1152921496;

    typedef struct packed {
        logic [29:0] m00;
        logic [29:0] m01;
        logic [29:0] m10;
        logic [29:0] m11;
        logic [62:0] exponent;
    } t_in_req;

    typedef struct packed {
        logic [29:0] r00;
        logic [29:0] r01;
        logic [29:0] r10;
        logic [29:0] r11;
    } t_out_req;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_RED  = 9'b000000010,
        ST_NEXT = 9'b000000100,
        ST_MUL  = 9'b000001000,
        ST_QEST = 9'b000010000,
        ST_QMUL = 9'b000100000,
        ST_FIX  = 9'b001000000,
        ST_ADD  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

endpackage

// ===== hw/rtl/modular_matrix_power_core.sv =====
// ----------------------------------------------------------------------------
// modular_matrix_power_core
// Raises a 2x2 matrix modulo 1000000007 to a 63-bit power.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one request with four matrix entries and
// an exponent; the output channel returns one request with the four result
// entries. A request is accepted when valid is high and stall is low.
// The block works on one request at a time: o_in_stall is high from the
// accept until the result has been taken.
// One shared 31x31 multiplier serves both the matrix terms and a Barrett
// reduction modulo the prime. Each term runs through multiply, quotient
// estimate, quotient times prime, correction and accumulate.
// A matrix product is eight terms, plus a sequencing step in ST_NEXT.
// Each exponent bit up to the top set bit costs one square, and each set
// bit costs one multiply more.
// The result appears once the input entries are reduced and all squares and
// multiplies are done; a zero exponent goes straight to the output. The input
// entries are reduced one at a time. The next request can be accepted in the
// cycle after the result is taken. Only the low EXP_BITS exponent bits count.
// Reset returns the sequencer to idle; no request is held.
// While the receiver stalls, the result holds on the output and no new
// request is accepted.
// ----------------------------------------------------------------------------
module modular_matrix_power_core
    import mmp_pkg::*;
#(
    parameter int EXP_BITS = DEF_EXP_BITS
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_data
);

    // Exponent bits beyond the field width are not present.
    localparam int USED_BITS = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
    localparam logic [62:0] EXP_MASK = {63{1'b1}} >> (EXP_W - USED_BITS);

    t_state r_state;
    logic [29:0] r_acc [4];
    logic [29:0] r_sq  [4];
    logic [29:0] r_tmp [4];
    logic [62:0] r_ex;
    logic        r_is_sq;    // current product is the square
    logic [1:0]  r_ent;      // entry being built
    logic        r_k;        // term index
    logic [59:0] r_rem;      // term value being reduced
    logic [29:0] r_q;        // quotient estimate
    logic [31:0] r_qp;       // low bits of quotient times prime
    logic [29:0] r_sum;

    // Operand selection for the matrix term.
    logic [1:0]  w_ia, w_ib;
    logic [29:0] w_x, w_y;
    always_comb begin
        w_ia = {r_ent[1], r_k};
        w_ib = {r_k, r_ent[0]};
        w_x  = r_is_sq ? r_sq[w_ia] : r_acc[w_ia];
        w_y  = r_sq[w_ib];
    end

    // The shared multiplier: matrix term, quotient estimate or quotient times prime.
    logic [30:0] w_ma, w_mb;
    logic [61:0] w_prod;
    always_comb begin
        case (r_state)
            ST_QEST: begin
                w_ma = r_rem[59:29];
                w_mb = MU;
            end
            ST_QMUL: begin
                w_ma = {1'b0, r_q};
                w_mb = {1'b0, PRIME};
            end
            default: begin
                w_ma = {1'b0, w_x};
                w_mb = {1'b0, w_y};
            end
        endcase
        w_prod = {31'd0, w_ma} * {31'd0, w_mb};
    end

    // Barrett remainder is below three times P; at most two corrections.
    logic [31:0] w_diff, w_fix;
    logic [30:0] w_addsum, w_addred;
    always_comb begin
        w_diff = r_rem[31:0] - r_qp;
        if (w_diff >= PRIME_X2) begin
            w_fix = w_diff - PRIME_X2;
        end else if (w_diff >= {2'b00, PRIME}) begin
            w_fix = w_diff - {2'b00, PRIME};
        end else begin
            w_fix = w_diff;
        end
        w_addsum = {1'b0, r_sum} + {1'b0, r_rem[29:0]};
        w_addred = (w_addsum >= {1'b0, PRIME}) ? w_addsum - {1'b0, PRIME} : w_addsum;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_data  = '{r00: r_acc[0], r01: r_acc[1], r10: r_acc[2], r11: r_acc[3]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_sq[0] <= i_in_data.m00;
                        r_sq[1] <= i_in_data.m01;
                        r_sq[2] <= i_in_data.m10;
                        r_sq[3] <= i_in_data.m11;
                        r_acc[0] <= 30'd1; r_acc[1] <= 30'd0;
                        r_acc[2] <= 30'd0; r_acc[3] <= 30'd1;
                        r_ex    <= i_in_data.exponent & EXP_MASK;
                        r_ent   <= 2'd0;
                        r_is_sq <= 1'b0;
                        r_state <= ST_RED;
                    end
                end
                // Entries below 2^30 need at most one subtraction.
                ST_RED: begin
                    if (r_sq[r_ent] >= PRIME) r_sq[r_ent] <= r_sq[r_ent] - PRIME;
                    r_ent <= r_ent + 2'd1;
                    if (r_ent == 2'd3) r_state <= ST_NEXT;
                end
                // Decide the next product from the exponent bits.
                ST_NEXT: begin
                    r_ent <= 2'd0; r_k <= 1'b0; r_sum <= 30'd0;
                    if (r_ex == 63'd0) begin
                        r_state <= ST_OUT;
                    end else if (r_ex[0] && !r_is_sq) begin
                        r_is_sq <= 1'b0;
                        r_state <= ST_MUL;
                    end else begin
                        r_is_sq <= 1'b1;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_rem   <= w_prod[59:0];
                    r_state <= ST_QEST;
                end
                // Quotient estimate from the top bits of the term.
                ST_QEST: begin
                    r_q     <= w_prod[60:31];
                    r_state <= ST_QMUL;
                end
                ST_QMUL: begin
                    r_qp    <= w_prod[31:0];
                    r_state <= ST_FIX;
                end
                ST_FIX: begin
                    r_rem   <= {30'd0, w_fix[29:0]};
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    if (!r_k) begin
                        r_sum   <= w_addred[29:0];
                        r_k     <= 1'b1;
                        r_state <= ST_MUL;
                    end else begin
                        r_tmp[r_ent] <= w_addred[29:0];
                        r_sum <= 30'd0;
                        r_k   <= 1'b0;
                        if (r_ent != 2'd3) begin
                            r_ent   <= r_ent + 2'd1;
                            r_state <= ST_MUL;
                        end else begin
                            // Commit the finished product.
                            r_state <= ST_NEXT;
                            if (r_is_sq) begin
                                r_sq[0] <= r_tmp[0]; r_sq[1] <= r_tmp[1];
                                r_sq[2] <= r_tmp[2]; r_sq[3] <= w_addred[29:0];
                                r_ex    <= r_ex >> 1;
                                r_is_sq <= 1'b0;
                            end else begin
                                r_acc[0] <= r_tmp[0]; r_acc[1] <= r_tmp[1];
                                r_acc[2] <= r_tmp[2]; r_acc[3] <= w_addred[29:0];
                                r_is_sq  <= 1'b1;
                            end
                        end
                    end
                end
                ST_OUT: begin
                    r_is_sq <= 1'b0;
                    if (!i_out_stall) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // The reduced term is below P before the add.
    a_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |-> (r_rem < 60'd1000000007)) else $error("reduce");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid) else $error("hold");
    a_ent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_acc[0] < PRIME && r_acc[3] < PRIME)) else $error("range");

endmodule

// ===== tb/tb_modular_matrix_power_core.sv =====
// ----------------------------------------------------------------------------
// tb_modular_matrix_power_core
// Self-checking testbench for the modular matrix power block. A directed set
// of corner requests is followed by random requests, mostly with short
// exponents. Each accepted request is predicted by square-and-multiply
// modulo 1000000007, and results are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb_modular_matrix_power_core;
    import mmp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned MODULUS = 64'd1000000007;
    localparam int RANDOM_REQUESTS = 520;

    // Holds predicted result matrices and compares them with the block output.
    class power_scoreboard;
        t_out_req pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function longint unsigned mul_mod(longint unsigned a, longint unsigned b);
            return (a * b) % MODULUS;
        endfunction

        // Product of two 2x2 matrices modulo the prime.
        function void mat_mul(input longint unsigned x[4], input longint unsigned y[4],
                              output longint unsigned r[4]);
            r[0] = (mul_mod(x[0], y[0]) + mul_mod(x[1], y[2])) % MODULUS;
            r[1] = (mul_mod(x[0], y[1]) + mul_mod(x[1], y[3])) % MODULUS;
            r[2] = (mul_mod(x[2], y[0]) + mul_mod(x[3], y[2])) % MODULUS;
            r[3] = (mul_mod(x[2], y[1]) + mul_mod(x[3], y[3])) % MODULUS;
        endfunction

        // Notes an accepted request and queues its matrix power.
        function void note_request(t_in_req req);
            longint unsigned base[4];
            longint unsigned acc[4];
            longint unsigned tmp[4];
            logic [62:0] ex;
            t_out_req res;
            base[0] = longint'(req.m00) % MODULUS;
            base[1] = longint'(req.m01) % MODULUS;
            base[2] = longint'(req.m10) % MODULUS;
            base[3] = longint'(req.m11) % MODULUS;
            acc = '{1, 0, 0, 1};
            ex = req.exponent;
            while (ex != 0) begin
                if (ex[0]) begin
                    mat_mul(acc, base, tmp);
                    acc = tmp;
                end
                mat_mul(base, base, tmp);
                base = tmp;
                ex = ex >> 1;
            end
            res.r00 = acc[0][29:0];
            res.r01 = acc[1][29:0];
            res.r10 = acc[2][29:0];
            res.r11 = acc[3][29:0];
            pending = {pending, res};
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR: %s", msg);
        endtask

        // Compares one accepted result with the oldest prediction.
        task check_result(t_out_req got);
            t_out_req want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = pending.pop_front();
            if (got.r00 != want.r00) report($sformatf("r00 %0d want %0d", got.r00, want.r00));
            if (got.r01 != want.r01) report($sformatf("r01 %0d want %0d", got.r01, want.r01));
            if (got.r10 != want.r10) report($sformatf("r10 %0d want %0d", got.r10, want.r10));
            if (got.r11 != want.r11) report($sformatf("r11 %0d want %0d", got.r11, want.r11));
        endtask
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_in_req  i_in_data = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_out_req o_out_data;

    power_scoreboard sb = new();
    bit stim_done = 1'b0;

    always #5 i_clk = ~i_clk;

    modular_matrix_power_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Mostly short gaps, sometimes none, a few long.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 120);
    endfunction

    // Presents one request and holds it until accepted.
    task send_request(t_in_req req);
        @(negedge i_clk);
        i_in_data = req;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req);
    endtask

    task idle_sender(int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function logic [29:0] rand_entry();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 30'($urandom_range(0, 3));
        if (r == 1) return PRIME - 30'($urandom_range(1, 3));
        if (r == 2) return PRIME + 30'($urandom_range(0, 73741816));
        return 30'($urandom_range(0, 1000000006));
    endfunction

    // Short exponents keep the run time reasonable; a few span every bit.
    function logic [62:0] rand_exponent();
        int r;
        logic [62:0] e;
        r = $urandom_range(0, 99);
        e = 63'({$urandom, $urandom});
        if (r < 85) return e & 63'(($urandom_range(1, 3) == 1) ? 3 : 7);
        if (r < 99) return e & 63'hff;
        return e;
    endfunction

    function t_in_req make_req(logic [29:0] a, logic [29:0] b, logic [29:0] c,
                               logic [29:0] d, logic [62:0] e);
        t_in_req req;
        req.m00 = a;
        req.m01 = b;
        req.m10 = c;
        req.m11 = d;
        req.exponent = e;
        return req;
    endfunction

    // Receiver stall: bursts of stalling with calm stretches between.
    initial begin
        int len;
        @(posedge i_rst_n);
        forever begin
            len = pick_gap();
            @(negedge i_clk);
            i_out_stall = (len > 0);
            repeat (len > 0 ? len - 1 : $urandom_range(0, 30)) @(negedge i_clk);
            @(negedge i_clk);
            i_out_stall = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
    end

    // Stimulus.
    initial begin
        logic [29:0] top;
        logic [29:0] pm1;
        top = 30'h3fffffff;
        pm1 = PRIME - 30'd1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corners.
        send_request(make_req(30'd5, 30'd6, 30'd7, 30'd8, 63'd0));
        send_request(make_req(top, top, top, top, 63'd0));
        send_request(make_req(30'd0, 30'd0, 30'd0, 30'd0, 63'd1));
        send_request(make_req(pm1, pm1, pm1, pm1, 63'd1));
        send_request(make_req(PRIME, PRIME + 30'd1, top, top - 30'd1, 63'd1));
        idle_sender(pick_gap());
        send_request(make_req(pm1, 30'd1, 30'd2, pm1, 63'd2));
        send_request(make_req(30'd1, 30'd1, 30'd1, 30'd0, 63'd10));
        send_request(make_req(30'd1, 30'd0, 30'd0, 30'd1, 63'd3));
        send_request(make_req(top, 30'd0, 30'd0, top, 63'd5));
        send_request(make_req(30'd2, 30'd0, 30'd0, 30'd2, 63'd30));
        send_request(make_req(30'd3, 30'd5, 30'd7, 30'd11, {63{1'b1}}));
        send_request(make_req(pm1, 30'd2, 30'd3, PRIME - 30'd2, 63'h4000000000000000));
        send_request(make_req(30'd123456789, 30'd987654321, 30'd555555555, 30'd1,
                              63'h2aaaaaaaaaaaaaaa));

        // Random requests, with one full drain partway through.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 2) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                wait (sb.pending.size() == 0);
                repeat (20) @(negedge i_clk);
            end else begin
                idle_sender(pick_gap());
            end
            send_request(make_req(rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                                  rand_exponent()));
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
        stim_done = 1'b1;
    end

    // Completion.
    initial begin
        wait (stim_done);
        wait (sb.pending.size() == 0);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_modular_matrix_power_core OK");
        end else begin
            $display("tb_modular_matrix_power_core NOT OK");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #400_000_000;
        $display("tb_modular_matrix_power_core NOT OK");
        $finish;
    end

endmodule
